/* hw/rtl/bhp_pkg.sv */
// Shared constants for the bundle header parser: parse phase codes,
// status codes, the signature byte table and the header field constants.
// No dependencies.
package bhp_pkg;

  typedef logic [3:0] phase_t;
  typedef logic [1:0] status_t;

  localparam phase_t PH_SIG      = 4'd0;
  localparam phase_t PH_VER      = 4'd1;
  localparam phase_t PH_TXT1     = 4'd2;
  localparam phase_t PH_TXT2     = 4'd3;
  localparam phase_t PH_SIZE     = 4'd4;
  localparam phase_t PH_PACKED   = 4'd5;
  localparam phase_t PH_UNPACKED = 4'd6;
  localparam phase_t PH_FLAGS    = 4'd7;
  localparam phase_t PH_DONE     = 4'd8;
  localparam phase_t PH_SKIP     = 4'd9;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_TOO_SHORT = 2'd1;
  localparam status_t ST_BAD_SIG   = 2'd2;
  localparam status_t ST_TRUNC     = 2'd3;

  // Seven signature characters, then the terminating zero byte.
  localparam logic [7:0] SIG_BYTES [8] = '{
    8'h55, 8'h6E, 8'h69, 8'h74, 8'h79, 8'h46, 8'h53, 8'h00
  };

  localparam logic [31:0] MIN_VERSION = 32'd6;
  localparam int unsigned KIND_W      = 6;
  localparam int unsigned AT_END_BIT  = 7;
  localparam int unsigned DOFS_W      = 24;

endpackage

/* hw/rtl/bundle_header_parser_top.sv */
// Bundle header parser top level: byte-wide header parse state and result register.
// Depends on bhp_pkg.
//
// The result of a buffer is valid in the cycle after its last byte is accepted.
// Throughput: one byte per cycle while no held result stalls the input; a single
//   state-update stage between the parse registers and the result register sets this figure.
// Reset (rst_ni low, asynchronous): parse state returns to the signature phase with all
//   fields zero, and the result register is emptied.
module bundle_header_parser_top #(
  parameter int unsigned OFFSET_BITS = 24,
  parameter int unsigned MIN_LENGTH  = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // byte stream in
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      last_byte_i,
  // header result out
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output bhp_pkg::status_t          status_o,
  output logic [31:0]               format_version_o,
  output logic [63:0]               bundle_size_o,
  output logic [31:0]               packed_info_size_o,
  output logic [31:0]               unpacked_info_size_o,
  output logic [31:0]               header_flags_o,
  output logic [bhp_pkg::KIND_W-1:0] compression_kind_o,
  output logic                      info_at_end_o,
  output logic [bhp_pkg::DOFS_W-1:0] data_offset_o
);
  import bhp_pkg::*;

  localparam int unsigned CNT_W = $clog2(MIN_LENGTH + 1);
  localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_LENGTH);
  localparam logic [OFFSET_BITS-1:0] OFS_MAX = {OFFSET_BITS{1'b1}};

  // Parse state registers
  phase_t                 phase_q, phase_d;
  logic [2:0]             idx_q, idx_d;
  logic [OFFSET_BITS-1:0] offset_q, offset_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic                   sig_bad_q, sig_bad_d;
  logic [31:0]            version_q, version_d;
  logic [63:0]            size_q, size_d;
  logic [31:0]            packed_q, packed_d;
  logic [31:0]            unpacked_q, unpacked_d;
  logic [31:0]            flags_q, flags_d;

  // State after consuming the current byte, before any end-of-buffer clear
  phase_t                 phase_n;
  logic [2:0]             idx_n;
  logic [OFFSET_BITS-1:0] offset_n;
  logic [CNT_W-1:0]       count_n;
  logic                   sig_bad_n;
  logic [31:0]            version_n;
  logic [63:0]            size_n;
  logic [31:0]            packed_n;
  logic [31:0]            unpacked_n;
  logic [31:0]            flags_n;

  // Result register
  logic                   out_valid_q, out_valid_d;
  status_t                res_status;
  logic [31:0]            offset_ext;

  logic in_fire;
  logic res_load;

  // The result register frees up in the same cycle it is drained, so a new
  // byte can enter while a finished result is being taken.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign res_load   = in_fire && last_byte_i;

  // ---------------------------------------------------------------------------
  // Byte consume step: one phase decode and one field shift per byte.
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_n    = phase_q;
    idx_n      = idx_q;
    offset_n   = offset_q;
    sig_bad_n  = sig_bad_q;
    version_n  = version_q;
    size_n     = size_q;
    packed_n   = packed_q;
    unpacked_n = unpacked_q;
    flags_n    = flags_q;

    // Total length saturates at the minimum length; only "reached" matters.
    count_n = (count_q < CNT_MIN) ? count_q + 1'b1 : count_q;

    // Header bytes are counted only while the header is still being parsed.
    if (phase_q != PH_DONE && phase_q != PH_SKIP) begin
      if (offset_q != OFS_MAX) begin
        offset_n = offset_q + 1'b1;
      end
      unique case (phase_q)
        PH_SIG: begin
          // The table's eighth entry is the zero terminator.
          if (data_byte_i != SIG_BYTES[idx_q]) begin
            sig_bad_n = 1'b1;
            phase_n   = PH_SKIP;
          end else if (idx_q == 3'd7) begin
            phase_n = PH_VER;
            idx_n   = 3'd0;
          end else begin
            idx_n = idx_q + 3'd1;
          end
        end
        PH_VER: begin
          version_n = {version_q[23:0], data_byte_i};
          if (idx_q == 3'd3) begin
            phase_n = PH_TXT1;
            idx_n   = 3'd0;
          end else begin
            idx_n = idx_q + 3'd1;
          end
        end
        PH_TXT1: begin
          if (data_byte_i == 8'h00) begin
            phase_n = PH_TXT2;
          end
        end
        PH_TXT2: begin
          if (data_byte_i == 8'h00) begin
            // Old formats carry no size or flags words.
            phase_n = (version_q >= MIN_VERSION) ? PH_SIZE : PH_DONE;
            idx_n   = 3'd0;
          end
        end
        PH_SIZE: begin
          size_n = {size_q[55:0], data_byte_i};
          if (idx_q == 3'd7) begin
            phase_n = PH_PACKED;
            idx_n   = 3'd0;
          end else begin
            idx_n = idx_q + 3'd1;
          end
        end
        PH_PACKED: begin
          packed_n = {packed_q[23:0], data_byte_i};
          if (idx_q == 3'd3) begin
            phase_n = PH_UNPACKED;
            idx_n   = 3'd0;
          end else begin
            idx_n = idx_q + 3'd1;
          end
        end
        PH_UNPACKED: begin
          unpacked_n = {unpacked_q[23:0], data_byte_i};
          if (idx_q == 3'd3) begin
            phase_n = PH_FLAGS;
            idx_n   = 3'd0;
          end else begin
            idx_n = idx_q + 3'd1;
          end
        end
        PH_FLAGS: begin
          flags_n = {flags_q[23:0], data_byte_i};
          if (idx_q == 3'd3) begin
            phase_n = PH_DONE;
            idx_n   = 3'd0;
          end else begin
            idx_n = idx_q + 3'd1;
          end
        end
        default: begin
          // Unused phase codes park in the skip phase.
          phase_n = PH_SKIP;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // End-of-buffer status. Too short wins over bad signature, which wins over
  // truncated. A signature cut off before its seventh character is bad.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (count_n < CNT_MIN) begin
      res_status = ST_TOO_SHORT;
    end else if (sig_bad_n || (phase_n == PH_SIG && idx_n != 3'd7)) begin
      res_status = ST_BAD_SIG;
    end else if (phase_n != PH_DONE) begin
      res_status = ST_TRUNC;
    end else begin
      res_status = ST_OK;
    end
  end

  assign offset_ext = 32'(offset_n);

  // Commit the step on an accepted byte; clear everything after the last one
  // so the next buffer starts from a clean state.
  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    offset_d   = offset_q;
    count_d    = count_q;
    sig_bad_d  = sig_bad_q;
    version_d  = version_q;
    size_d     = size_q;
    packed_d   = packed_q;
    unpacked_d = unpacked_q;
    flags_d    = flags_q;
    if (in_fire) begin
      if (last_byte_i) begin
        phase_d    = PH_SIG;
        idx_d      = '0;
        offset_d   = '0;
        count_d    = '0;
        sig_bad_d  = 1'b0;
        version_d  = '0;
        size_d     = '0;
        packed_d   = '0;
        unpacked_d = '0;
        flags_d    = '0;
      end else begin
        phase_d    = phase_n;
        idx_d      = idx_n;
        offset_d   = offset_n;
        count_d    = count_n;
        sig_bad_d  = sig_bad_n;
        version_d  = version_n;
        size_d     = size_n;
        packed_d   = packed_n;
        unpacked_d = unpacked_n;
        flags_d    = flags_n;
      end
    end
  end

  // Hold a result until taken; load a new one on the last byte of a buffer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SIG;
      idx_q       <= '0;
      offset_q    <= '0;
      count_q     <= '0;
      sig_bad_q   <= 1'b0;
      version_q   <= '0;
      size_q      <= '0;
      packed_q    <= '0;
      unpacked_q  <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      offset_q    <= offset_d;
      count_q     <= count_d;
      sig_bad_q   <= sig_bad_d;
      version_q   <= version_d;
      size_q      <= size_d;
      packed_q    <= packed_d;
      unpacked_q  <= unpacked_d;
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload: a failed buffer reports zero in every field but status.
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      status_o <= res_status;
      if (res_status == ST_OK) begin
        format_version_o     <= version_n;
        bundle_size_o        <= size_n;
        packed_info_size_o   <= packed_n;
        unpacked_info_size_o <= unpacked_n;
        header_flags_o       <= flags_n;
        compression_kind_o   <= flags_n[KIND_W-1:0];
        info_at_end_o        <= flags_n[AT_END_BIT];
        data_offset_o        <= offset_ext[DOFS_W-1:0];
      end else begin
        format_version_o     <= '0;
        bundle_size_o        <= '0;
        packed_info_size_o   <= '0;
        unpacked_info_size_o <= '0;
        header_flags_o       <= '0;
        compression_kind_o   <= '0;
        info_at_end_o        <= 1'b0;
        data_offset_o        <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/bhp_checker.sv */
// Port-level checks for the bundle header parser, bound to its top level.
// Depends on bhp_pkg and bundle_header_parser_top.
module bhp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        last_byte_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input bhp_pkg::status_t            status_o,
  input logic [31:0]                 format_version_o,
  input logic [31:0]                 header_flags_o,
  input logic [bhp_pkg::KIND_W-1:0]  compression_kind_o,
  input logic                        info_at_end_o,
  input logic [bhp_pkg::DOFS_W-1:0]  data_offset_o
);
  import bhp_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(status_o) && $stable(data_offset_o))
    else $error("result changed while stalled");

  // An empty result slot never blocks input.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result slot");

  // A new result appears only after an accepted last byte.
  a_res_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && last_byte_i))
    else $error("result without last byte");

  // Failed buffers report zero fields.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |->
      format_version_o == '0 && header_flags_o == '0 && data_offset_o == '0)
    else $error("failed result carries field data");

  // Derived flag fields agree with the flags word.
  a_flag_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      compression_kind_o == header_flags_o[KIND_W-1:0] &&
      info_at_end_o == header_flags_o[AT_END_BIT])
    else $error("flag fields disagree with flags word");

endmodule

bind bundle_header_parser_top bhp_checker u_bhp_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .last_byte_i        (last_byte_i),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .status_o           (status_o),
  .format_version_o   (format_version_o),
  .header_flags_o     (header_flags_o),
  .compression_kind_o (compression_kind_o),
  .info_at_end_o      (info_at_end_o),
  .data_offset_o      (data_offset_o)
);

/* verif/bundle_header_parser_top_tb.sv */
// Self-checking testbench for bundle_header_parser_top: byte streams in, one header result out.
// Depends on bhp_pkg and bundle_header_parser_top; a built-in parse predictor checks every result.
`timescale 1ns / 1ps
module bundle_header_parser_top_tb;
  import bhp_pkg::*;

  localparam int unsigned OFFSET_BITS = 24;
  localparam int unsigned MIN_LENGTH  = 32;
  localparam int unsigned MAX_GAP     = 18;

  typedef struct {
    status_t             status;
    logic [31:0]         version;
    logic [63:0]         size;
    logic [31:0]         packed_size;
    logic [31:0]         unpacked_size;
    logic [31:0]         flags;
    logic [KIND_W-1:0]   kind;
    logic                at_end;
    logic [DOFS_W-1:0]   offset;
  } header_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [7:0]          data_byte_i;
  logic                last_byte_i;
  logic                out_valid_o;
  logic                out_ready_i;
  status_t             status_o;
  logic [31:0]         format_version_o;
  logic [63:0]         bundle_size_o;
  logic [31:0]         packed_info_size_o;
  logic [31:0]         unpacked_info_size_o;
  logic [31:0]         header_flags_o;
  logic [KIND_W-1:0]   compression_kind_o;
  logic                info_at_end_o;
  logic [DOFS_W-1:0]   data_offset_o;

  bundle_header_parser_top #(
    .OFFSET_BITS(OFFSET_BITS),
    .MIN_LENGTH (MIN_LENGTH)
  ) u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .data_byte_i         (data_byte_i),
    .last_byte_i         (last_byte_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .format_version_o    (format_version_o),
    .bundle_size_o       (bundle_size_o),
    .packed_info_size_o  (packed_info_size_o),
    .unpacked_info_size_o(unpacked_info_size_o),
    .header_flags_o      (header_flags_o),
    .compression_kind_o  (compression_kind_o),
    .info_at_end_o       (info_at_end_o),
    .data_offset_o       (data_offset_o)
  );

  // Free-running clock, 10 ns period.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  header_result_t expected_headers [$];  // results still owed by the block, oldest first
  logic [7:0]     buf_q [$];             // buffer under construction
  int unsigned    mismatch_count = 0;
  int unsigned    bytes_sent     = 0;
  bit             tx_idle_on     = 1'b0;  // sender inserts random gaps
  bit             rx_idle_on     = 1'b0;  // receiver inserts random stalls
  int unsigned    rx_hold_request = 0;    // long receiver hold-off, in cycles

  // Parse state of the predictor; mirrors the header walk of the block.
  phase_t                 pm_phase;
  logic [2:0]             pm_idx;
  logic [OFFSET_BITS-1:0] pm_offset;
  int unsigned            pm_total;
  bit                     pm_sig_bad;
  logic [31:0]            pm_version;
  logic [63:0]            pm_size;
  logic [31:0]            pm_packed;
  logic [31:0]            pm_unpacked;
  logic [31:0]            pm_flags;

  // ---------------------------------------------------------------------------
  // Header parse predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_parse_state();
    pm_phase    = PH_SIG;
    pm_idx      = '0;
    pm_offset   = '0;
    pm_total    = 0;
    pm_sig_bad  = 1'b0;
    pm_version  = '0;
    pm_size     = '0;
    pm_packed   = '0;
    pm_unpacked = '0;
    pm_flags    = '0;
  endfunction

  // Advance the byte index inside a multi-byte field; move on after its final byte.
  function automatic void step_field(logic [2:0] final_idx, phase_t next_phase);
    if (pm_idx == final_idx) begin
      pm_phase = next_phase;
      pm_idx   = '0;
    end else begin
      pm_idx = pm_idx + 3'd1;
    end
  endfunction

  // Fold one accepted byte into the parse state; on the last byte queue the result.
  function automatic void parse_header_byte(logic [7:0] b, logic is_last);
    header_result_t r;
    if (pm_total < MIN_LENGTH) pm_total++;
    // Bytes past the header (or after a bad signature) only count toward length.
    if (pm_phase != PH_DONE && pm_phase != PH_SKIP) begin
      if (pm_offset != {OFFSET_BITS{1'b1}}) pm_offset = pm_offset + 1'b1;
      case (pm_phase)
        PH_SIG: begin
          // Table entry 7 is the zero terminator, so one compare covers all eight bytes.
          if (b != SIG_BYTES[pm_idx]) begin
            pm_sig_bad = 1'b1;
            pm_phase   = PH_SKIP;
          end else begin
            step_field(3'd7, PH_VER);
          end
        end
        PH_VER: begin
          pm_version = {pm_version[23:0], b};
          step_field(3'd3, PH_TXT1);
        end
        PH_TXT1: begin
          if (b == 8'h00) pm_phase = PH_TXT2;
        end
        PH_TXT2: begin
          if (b == 8'h00) begin
            pm_phase = (pm_version >= MIN_VERSION) ? PH_SIZE : PH_DONE;
            pm_idx   = '0;
          end
        end
        PH_SIZE: begin
          pm_size = {pm_size[55:0], b};
          step_field(3'd7, PH_PACKED);
        end
        PH_PACKED: begin
          pm_packed = {pm_packed[23:0], b};
          step_field(3'd3, PH_UNPACKED);
        end
        PH_UNPACKED: begin
          pm_unpacked = {pm_unpacked[23:0], b};
          step_field(3'd3, PH_FLAGS);
        end
        PH_FLAGS: begin
          pm_flags = {pm_flags[23:0], b};
          step_field(3'd3, PH_DONE);
        end
        default: pm_phase = PH_SKIP;
      endcase
    end
    if (!is_last) return;

    // Status priority: too short, then bad signature, then truncated.
    r = '{default: '0};
    if (pm_total < MIN_LENGTH)
      r.status = ST_TOO_SHORT;
    else if (pm_sig_bad || (pm_phase == PH_SIG && pm_idx < 3'd7))
      r.status = ST_BAD_SIG;
    else if (pm_phase != PH_DONE)
      r.status = ST_TRUNC;
    else
      r.status = ST_OK;

    // A failed result carries zeros in every other field.
    if (r.status == ST_OK) begin
      r.version       = pm_version;
      r.size          = pm_size;
      r.packed_size   = pm_packed;
      r.unpacked_size = pm_unpacked;
      r.flags         = pm_flags;
      r.kind          = pm_flags[KIND_W-1:0];
      r.at_end        = pm_flags[AT_END_BIT];
      r.offset        = pm_offset[DOFS_W-1:0];
    end
    expected_headers.push_back(r);
    clear_parse_state();
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one byte per call, random gap drawn per byte
  // ---------------------------------------------------------------------------
  function automatic int unsigned draw_gap(bit enabled);
    if (!enabled || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, MAX_GAP);
  endfunction

  // Called at a clock edge; drop valid only when a gap is drawn, so valid
  // gets a single update per edge for back-to-back bytes.
  task automatic send_byte(logic [7:0] b, logic is_last);
    int unsigned gap;
    gap = draw_gap(tx_idle_on);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
    parse_header_byte(b, is_last);
    bytes_sent++;
  endtask

  // Send the buffer under construction with last marked on its final byte, then clear it.
  task automatic send_buffer();
    int n;
    n = buf_q.size();
    for (int i = 0; i < n; i++) send_byte(buf_q[i], i == n - 1);
    buf_q.delete();
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
  endtask

  // Hold the sender until the block has returned every owed result.
  task automatic wait_results_drained();
    while (expected_headers.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Buffer construction helpers
  // ---------------------------------------------------------------------------
  task automatic push_word(logic [63:0] value, int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) buf_q.push_back(value[8*i +: 8]);
  endtask

  // Zero-terminated text with nonzero content.
  task automatic push_text(int len);
    repeat (len) buf_q.push_back(8'($urandom_range(1, 255)));
    buf_q.push_back(8'h00);
  endtask

  task automatic push_header(logic [31:0] ver, logic [63:0] sz, logic [31:0] pk,
                             logic [31:0] upk, logic [31:0] fl, int t1, int t2);
    for (int i = 0; i < 8; i++) buf_q.push_back(SIG_BYTES[i]);
    push_word(64'(ver), 4);
    push_text(t1);
    push_text(t2);
    if (ver >= MIN_VERSION) begin
      push_word(sz, 8);
      push_word(64'(pk), 4);
      push_word(64'(upk), 4);
      push_word(64'(fl), 4);
    end
  endtask

  task automatic pad_to(int len);
    while (buf_q.size() < len) buf_q.push_back(8'($urandom()));
  endtask

  task automatic cut_to(int len);
    while (buf_q.size() > len) void'(buf_q.pop_back());
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stall per result, plus long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned stall_left;
    bit          taken;
    hold_left   = 0;
    stall_left  = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      taken = out_valid_o && out_ready_i;
      if (rx_hold_request != 0) begin
        hold_left       = rx_hold_request;
        rx_hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (taken) stall_left = draw_gap(rx_idle_on);
        if (stall_left != 0) begin
          stall_left--;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    header_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_headers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d",
                 $time, status_o);
        mismatch_count++;
      end else begin
        want = expected_headers.pop_front();
        compare_field("status",             64'(want.status),  64'(status_o));
        compare_field("format_version",     64'(want.version), 64'(format_version_o));
        compare_field("bundle_size",        want.size,         bundle_size_o);
        compare_field("packed_info_size",   64'(want.packed_size),
                      64'(packed_info_size_o));
        compare_field("unpacked_info_size", 64'(want.unpacked_size),
                      64'(unpacked_info_size_o));
        compare_field("header_flags",       64'(want.flags),   64'(header_flags_o));
        compare_field("compression_kind",   64'(want.kind),    64'(compression_kind_o));
        compare_field("info_at_end",        64'(want.at_end),  64'(info_at_end_o));
        compare_field("data_offset",        64'(want.offset),  64'(data_offset_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Well-formed headers: field extremes, old and new versions, exact minimum length.
  task automatic test_good_headers();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    // All-ones fields, empty texts: compression kind 63 and info-at-end set.
    push_header(32'd6, '1, '1, '1, '1, 0, 0);
    send_buffer();
    // Largest version with zero fields and trailing bytes after the header.
    push_header(32'hFFFF_FFFF, '0, '0, '0, '0, 3, 2);
    pad_to(buf_q.size() + 9);
    send_buffer();
    // Old version: size words are absent, and the buffer is exactly the minimum length.
    push_header(32'd5, '0, '0, '0, '0, 1, 0);
    pad_to(MIN_LENGTH);
    send_buffer();
    push_header(32'd0, '0, '0, '0, '0, 4, 4);
    pad_to(40);
    send_buffer();
    // Compression kind 3, blocks info at end.
    push_header(32'd7, 64'h0123_4567_89AB_CDEF, 32'h0000_1000, 32'h0000_2000,
                32'h0000_0083, 1, 1);
    send_buffer();
    idle_input();
    wait_results_drained();
  endtask

  // Each failing status and each way of cutting a buffer short.
  task automatic test_error_headers();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    // Single-byte buffer.
    buf_q.push_back(SIG_BYTES[0]);
    send_buffer();
    // Signature cut after three bytes, and right after all seven characters.
    push_header(32'd6, '0, '0, '0, '0, 0, 0);
    cut_to(3);
    send_buffer();
    push_header(32'd6, '0, '0, '0, '0, 0, 0);
    cut_to(7);
    send_buffer();
    // Complete old-version header one byte short of the minimum length.
    push_header(32'd2, '0, '0, '0, '0, 2, 2);
    pad_to(MIN_LENGTH - 1);
    send_buffer();
    // Wrong first byte.
    buf_q.push_back(8'h00);
    pad_to(MIN_LENGTH);
    send_buffer();
    // Last signature character wrong.
    push_header(32'd6, '0, '0, '0, '0, 0, 0);
    buf_q[6] = 8'h54;
    pad_to(MIN_LENGTH);
    send_buffer();
    // Nonzero terminator after the signature.
    push_header(32'd6, '0, '0, '0, '0, 0, 0);
    buf_q[7] = 8'h01;
    pad_to(MIN_LENGTH);
    send_buffer();
    // First text never terminated.
    push_header(32'd6, '0, '0, '0, '0, 0, 0);
    cut_to(12);
    repeat (30) buf_q.push_back(8'($urandom_range(1, 255)));
    send_buffer();
    // Flags word cut short.
    push_header(32'd9, rand64(), $urandom(), $urandom(), $urandom(), 2, 3);
    cut_to(buf_q.size() - 2);
    send_buffer();
    idle_input();
    wait_results_drained();
  endtask

  // Stall the result side for a long stretch while bytes keep coming, so the
  // block fills and stalls its input; then pause until all results return.
  task automatic test_backpressure();
    tx_idle_on      = 1'b0;
    rx_idle_on      = 1'b0;
    rx_hold_request = 200;
    repeat (10) begin
      buf_q.push_back(8'($urandom()));
      send_buffer();
    end
    repeat (3) begin
      push_header(32'd6, rand64(), $urandom(), $urandom(), $urandom(), 1, 2);
      send_buffer();
    end
    idle_input();
    wait_results_drained();
  endtask

  // Random buffers: mostly well-formed headers with random content, the rest
  // corrupted signatures, cut-off headers and noise.
  task automatic test_random_buffers(int unsigned byte_budget);
    int unsigned n_buf;
    int unsigned pick;
    int unsigned pos;
    logic [31:0] ver;
    n_buf = 0;
    while (bytes_sent < byte_budget) begin
      // Rotate through the four sender/receiver idling combinations.
      tx_idle_on = ((n_buf / 8) % 4) inside {1, 3};
      rx_idle_on = ((n_buf / 8) % 4) >= 2;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) begin
        ver = $urandom();
        if (ver < MIN_VERSION) ver = MIN_VERSION;
      end else begin
        ver = $urandom_range(6, 9);
      end
      if (pick < 55) begin
        push_header(ver, rand64(), $urandom(), $urandom(), $urandom(),
                    $urandom_range(0, 10), $urandom_range(0, 10));
        pad_to(buf_q.size() + $urandom_range(0, 16));
      end else if (pick < 70) begin
        push_header($urandom_range(0, 5), '0, '0, '0, '0,
                    $urandom_range(0, 10), $urandom_range(0, 10));
        pad_to($urandom_range(14, 48));
      end else if (pick < 80) begin
        push_header(ver, rand64(), $urandom(), $urandom(), $urandom(),
                    $urandom_range(0, 6), $urandom_range(0, 6));
        pos = $urandom_range(0, 7);
        buf_q[pos] = buf_q[pos] ^ 8'($urandom_range(1, 255));
        pad_to(MIN_LENGTH);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 64)) buf_q.push_back(8'($urandom()));
      end else begin
        push_header(ver, rand64(), $urandom(), $urandom(), $urandom(),
                    $urandom_range(0, 12), $urandom_range(0, 12));
        cut_to($urandom_range(1, buf_q.size()));
      end
      send_buffer();
      n_buf++;
    end
    idle_input();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    clear_parse_state();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_good_headers();
    test_error_headers();
    test_backpressure();
    test_random_buffers(1800);

    // Drain, then allow the registered result to settle.
    wait_results_drained();
    repeat (5) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
